### hdl/rcs_pkg.sv
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants for the region centroid statistics block.
// ----------------------------------------------------------------------------
package rcs_pkg;

  localparam int unsigned MaxLabelsDefault    = 64;
  localparam int unsigned MaxDimDefault       = 4096;
  localparam int unsigned FractionBitsDefault = 8;

  localparam int unsigned LabelW  = 7;
  localparam int unsigned IdW     = 6;
  localparam int unsigned AreaW   = 25;
  localparam int unsigned CentW   = 20;
  localparam int unsigned WidthW  = 13;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned SumW    = 36;
  localparam logic [WidthW-1:0] WidthReset = 13'd640;

  typedef struct packed {
    logic signed [LabelW-1:0] pixel_label;
    logic                     frame_end;
  } pixel_t;

  typedef struct packed {
    logic [IdW-1:0]   region_id;
    logic [AreaW-1:0] region_area;
    logic [CentW-1:0] centroid_x;
    logic [CentW-1:0] centroid_y;
    logic             last_region;
  } result_t;

  // Classified request from the front part to the back part.
  typedef struct packed {
    logic              hit;
    logic [IdW-1:0]    label;
    logic [CoordW-1:0] col;
    logic [CoordW-1:0] row;
    logic              frame_end;
  } cmd_t;

endpackage

### hdl/region_centroid_stats.sv
// ----------------------------------------------------------------------------
// region_centroid_stats
// Per-label area and centroid of a raster-ordered labelled image.
//
// Input queue: push with pixel_i while full is low; one pixel per request.
// Result queue: while empty is low, result_o holds the oldest result;
// pop takes it. Configuration: cfg_we_i writes the image width; the user must
// write it only while idle; the block leaves this to the user. Each pixel
// reads the per-label statistics memories in the accumulate unit and, for an
// in-range label, writes them back; the next pixel is taken only after that
// step. At frame end the unit scans labels 1 to MAX_LABELS-1; for each
// present label the one-bit-per-cycle divider shared by x and y computes
// both centroids in turn, and a final flush step flags the last result of
// the frame. After reset the statistics memories are cleared in a pass over
// all MAX_LABELS entries, during which requests wait in the input queue.
// When the receiver stalls, results back up into the result queue and then
// the scan holds; pixels keep queueing until the input queue reports full.
// ----------------------------------------------------------------------------
module region_centroid_stats #(
  parameter int unsigned MAX_LABELS    = rcs_pkg::MaxLabelsDefault,
  parameter int unsigned MAX_DIM       = rcs_pkg::MaxDimDefault,
  parameter int unsigned FRACTION_BITS = rcs_pkg::FractionBitsDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rcs_pkg::WidthW-1:0] cfg_wdata_i,
  input  logic                       push,
  input  rcs_pkg::pixel_t            pixel_i,
  output logic                       full,
  input  logic                       pop,
  output rcs_pkg::result_t           result_o,
  output logic                       empty
);
  logic [rcs_pkg::WidthW-1:0] width_q;
  rcs_pkg::cmd_t    cmd_in, cmd_out;
  logic             cmd_empty, cmd_pop;
  logic             bres_push, bres_full, bres_flush;
  rcs_pkg::result_t bres;
  logic             res_push, res_full;
  rcs_pkg::result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= rcs_pkg::WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  rcs_front #(.MAX_LABELS(MAX_LABELS), .MAX_DIM(MAX_DIM)) u_front (
    .clk_i, .rst_ni, .width_i(width_q),
    .valid_i(push && !full), .pixel_i, .cmd_o(cmd_in)
  );

  rcs_queue #(.DEPTH(4), .W($bits(rcs_pkg::cmd_t))) u_cmdq (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(cmd_in), .full_o(full),
    .pop_i(cmd_pop), .data_o(cmd_out), .empty_o(cmd_empty)
  );

  rcs_back #(.MAX_LABELS(MAX_LABELS), .FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i, .rst_ni,
    .cmd_i(cmd_out), .cmd_empty_i(cmd_empty), .cmd_pop_o(cmd_pop),
    .res_push_o(bres_push), .res_o(bres), .res_flush_o(bres_flush),
    .res_full_i(bres_full)
  );

  rcs_out u_out (
    .clk_i, .rst_ni,
    .push_i(bres_push), .res_i(bres), .flush_i(bres_flush), .full_o(bres_full),
    .push_o(res_push), .res_o(res), .full_i(res_full)
  );

  rcs_queue #(.DEPTH(4), .W($bits(rcs_pkg::result_t))) u_resq (
    .clk_i, .rst_ni,
    .push_i(res_push), .data_i(res), .full_o(res_full),
    .pop_i(pop), .data_o(result_o), .empty_o(empty)
  );
endmodule

### hdl/rcs_front.sv
// ----------------------------------------------------------------------------
// rcs_front
// Tracks column and row, classifies labels and forms the requests for a queue.
// ----------------------------------------------------------------------------
module rcs_front #(
  parameter int unsigned MAX_LABELS = rcs_pkg::MaxLabelsDefault,
  parameter int unsigned MAX_DIM    = rcs_pkg::MaxDimDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rcs_pkg::WidthW-1:0]    width_i,
  input  logic                          valid_i,
  input  rcs_pkg::pixel_t               pixel_i,
  output rcs_pkg::cmd_t                 cmd_o
);
  logic [rcs_pkg::CoordW-1:0] col_q, col_d, row_q, row_d;
  logic [rcs_pkg::WidthW-1:0] eff_w;
  logic [rcs_pkg::WidthW-1:0] col_next;
  logic [rcs_pkg::LabelW-1:0] max_lab;
  logic                       in_range;

  assign max_lab  = rcs_pkg::LabelW'(MAX_LABELS);
  assign in_range = (pixel_i.pixel_label > 0) &&
                    ($unsigned(pixel_i.pixel_label) < max_lab);

  always_comb begin
    if (width_i == '0 || width_i > rcs_pkg::WidthW'(MAX_DIM)) begin
      eff_w = rcs_pkg::WidthW'(MAX_DIM);
    end else begin
      eff_w = width_i;
    end
    col_next = rcs_pkg::WidthW'(col_q) + 1'b1;
    col_d = col_q;
    row_d = row_q;
    if (valid_i) begin
      if (pixel_i.frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (col_next >= eff_w) begin
        col_d = '0;
        // wrap the row counter at the maximum dimension
        row_d = (row_q == rcs_pkg::CoordW'(MAX_DIM-1)) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_next[rcs_pkg::CoordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign cmd_o.hit       = in_range;
  assign cmd_o.label     = pixel_i.pixel_label[rcs_pkg::IdW-1:0];
  assign cmd_o.col       = col_q;
  assign cmd_o.row       = row_q;
  assign cmd_o.frame_end = pixel_i.frame_end;
endmodule

### hdl/rcs_queue.sv
// ----------------------------------------------------------------------------
// rcs_queue
// Small FIFO, used as the request queue between front and back and as the result queue.
// ----------------------------------------------------------------------------
module rcs_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned W     = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i && !full_o) begin
        wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i && !empty_o) begin
        rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i && !full_o) - (AW+1)'(pop_i && !empty_o);
    end
  end
endmodule

### hdl/rcs_div.sv
// ----------------------------------------------------------------------------
// rcs_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcs_div #(
  parameter int unsigned NW = 44,
  parameter int unsigned DW = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(NW+1);

  logic [NW-1:0] quo_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW:0]   trial;

  assign trial  = {rem_q[DW-1:0], quo_q[NW-1]};
  assign done_o = !busy_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(NW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end
endmodule

### hdl/rcs_back.sv
// ----------------------------------------------------------------------------
// rcs_back
// Accumulates per-label statistics in memories; at frame end, walks the
// labels, divides the sums and emits results, clearing each entry as it goes.
// ----------------------------------------------------------------------------
module rcs_back #(
  parameter int unsigned MAX_LABELS    = rcs_pkg::MaxLabelsDefault,
  parameter int unsigned FRACTION_BITS = rcs_pkg::FractionBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rcs_pkg::cmd_t   cmd_i,
  input  logic            cmd_empty_i,
  output logic            cmd_pop_o,
  output logic            res_push_o,
  output rcs_pkg::result_t res_o,
  output logic            res_flush_o,
  input  logic            res_full_i
);
  localparam int unsigned LW = $clog2(MAX_LABELS);
  localparam int unsigned NW = rcs_pkg::SumW + FRACTION_BITS;
  localparam logic [rcs_pkg::AreaW-1:0] AreaLimit = rcs_pkg::AreaW'(1) << 24;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b0_0000_0001,
    S_IDLE  = 9'b0_0000_0010,
    S_RMW   = 9'b0_0000_0100,
    S_SCAN  = 9'b0_0000_1000,
    S_LOOK  = 9'b0_0001_0000,
    S_DIVX  = 9'b0_0010_0000,
    S_DIVY  = 9'b0_0100_0000,
    S_EMIT  = 9'b0_1000_0000,
    S_FLUSH = 9'b1_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [rcs_pkg::AreaW-1:0] area_mem [MAX_LABELS];
  logic [rcs_pkg::SumW-1:0]  xs_mem   [MAX_LABELS];
  logic [rcs_pkg::SumW-1:0]  ys_mem   [MAX_LABELS];

  logic [LW-1:0]             addr_q, addr_d;
  logic [rcs_pkg::AreaW-1:0] area_rd_q;
  logic [rcs_pkg::SumW-1:0]  xs_rd_q, ys_rd_q;
  logic                      found_q, found_d;
  logic [rcs_pkg::CentW-1:0] cx_q;
  logic                      we;
  logic [LW-1:0]             waddr;
  logic [rcs_pkg::AreaW-1:0] wa;
  logic [rcs_pkg::SumW-1:0]  wx, wy;
  logic                      rd_en;
  logic [LW-1:0]             raddr;
  logic                      div_start, div_done;
  logic [NW-1:0]             div_num, div_quo;
  logic                      last_lab;
  logic [LW-1:0]             next_nz;

  assign last_lab = (addr_q == LW'(MAX_LABELS-1));

  // Divider for both centroids.
  assign div_num = (state_q == S_LOOK) ? NW'(xs_rd_q) << FRACTION_BITS
                                        : NW'(ys_rd_q) << FRACTION_BITS;
  rcs_div #(.NW(NW), .DW(rcs_pkg::AreaW)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .num_i(div_num), .den_i(area_rd_q),
    .done_o(div_done), .quo_o(div_quo)
  );

  always_comb begin
    state_d   = state_q;
    addr_d    = addr_q;
    found_d   = found_q;
    cmd_pop_o = 1'b0;
    res_push_o = 1'b0;
    res_flush_o = 1'b0;
    we        = 1'b0;
    waddr     = addr_q;
    wa        = '0;
    wx        = '0;
    wy        = '0;
    rd_en     = 1'b0;
    raddr     = addr_q;
    div_start = 1'b0;
    res_o     = '0;
    next_nz   = addr_q + 1'b1;
    unique case (state_q)
      S_CLEAR: begin
        we = 1'b1;
        addr_d = addr_q + 1'b1;
        if (last_lab) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!cmd_empty_i) begin
          rd_en = 1'b1;
          raddr = cmd_i.label[LW-1:0];
          state_d = S_RMW;
        end
      end
      S_RMW: begin
        cmd_pop_o = 1'b1;
        if (cmd_i.hit && area_rd_q < AreaLimit) begin
          we = 1'b1;
          waddr = cmd_i.label[LW-1:0];
          wa = area_rd_q + 1'b1;
          wx = xs_rd_q + rcs_pkg::SumW'(cmd_i.col);
          wy = ys_rd_q + rcs_pkg::SumW'(cmd_i.row);
        end
        if (cmd_i.frame_end) begin
          addr_d  = LW'(1);
          found_d = 1'b0;
          state_d = S_SCAN;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        state_d = S_LOOK;
      end
      S_LOOK: begin
        if (area_rd_q != '0) begin
          div_start = 1'b1;
          state_d = S_DIVX;
        end else if (last_lab) begin
          state_d = found_q ? S_FLUSH : S_EMIT;
        end else begin
          addr_d = next_nz;
          state_d = S_SCAN;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        res_o.region_id   = (area_rd_q == '0) ? '0 : rcs_pkg::IdW'(addr_q);
        res_o.region_area = area_rd_q;
        res_o.centroid_x  = (area_rd_q == '0) ? '0 : cx_q;
        res_o.centroid_y  = (area_rd_q == '0) ? '0 : div_quo[rcs_pkg::CentW-1:0];
        if (!res_full_i) begin
          res_push_o = 1'b1;
          found_d = 1'b1;
          if (area_rd_q != '0) begin
            we = 1'b1;
          end
          if (last_lab || area_rd_q == '0) begin
            state_d = S_FLUSH;
          end else begin
            addr_d = next_nz;
            state_d = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        // mark the held result as the last one of the frame
        res_flush_o = 1'b1;
        if (!res_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // The last flag needs a look ahead: mark last when no later label is set.
  // Done by deferring: results are emitted one behind so the flag is known.

  always_ff @(posedge clk_i) begin
    if (we) begin
      area_mem[waddr] <= wa;
      xs_mem[waddr]   <= wx;
      ys_mem[waddr]   <= wy;
    end
    if (rd_en) begin
      area_rd_q <= area_mem[raddr];
      xs_rd_q   <= xs_mem[raddr];
      ys_rd_q   <= ys_mem[raddr];
    end
    if (state_q == S_DIVX && div_done) begin
      cx_q <= div_quo[rcs_pkg::CentW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      addr_q  <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      found_q <= found_d;
    end
  end
endmodule

### hdl/rcs_out.sv
// ----------------------------------------------------------------------------
// rcs_out
// Holds back one result so the final one of a frame can be flagged.
// ----------------------------------------------------------------------------
module rcs_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rcs_pkg::result_t res_i,
  input  logic             flush_i,
  output logic             full_o,
  output logic             push_o,
  output rcs_pkg::result_t res_o,
  input  logic             full_i
);
  logic             held_q;
  rcs_pkg::result_t hold_q;

  // Release the held result when a newer one arrives (not last) or at flush.
  always_comb begin
    push_o = 1'b0;
    res_o  = hold_q;
    if (held_q && (push_i || flush_i)) begin
      push_o = 1'b1;
      res_o.last_region = flush_i && !push_i;
    end
    full_o = held_q && full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (!full_o) begin
      if (push_i) begin
        held_q <= 1'b1;
      end else if (flush_i) begin
        held_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) begin
      hold_q <= res_i;
    end
  end
endmodule
